[sv/pps_pkg.sv]
// Package for the particle pair separation block.
// Fixed field widths and the register reset value; no dependencies.
package pps_pkg;

    localparam int MAG_W = 31;                    // |d|, distance, shares, corrections
    localparam int SQ_W = 2 * MAG_W;              // squared magnitudes
    localparam int INVM_W = 24;                   // inverse mass, Q8.16
    localparam int WSUM_W = INVM_W + 1;           // sum of two inverse masses
    localparam int SHNUM_W = MAG_W + INVM_W;      // overlap times inverse mass
    localparam int MINSEP_W = 31;
    localparam logic [MINSEP_W-1:0] MINSEP_RESET = 31'd6554;

endpackage

[sv/pps_delay.sv]
// Delay line that keeps a request's fields and valid bit in step with a
// pipelined arithmetic unit. No package dependency.
module pps_delay #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         v_i,
    input  logic [W-1:0] d_i,
    output logic         v_o,
    output logic [W-1:0] d_o
);

    logic [N-1:0] v_reg;
    logic [W-1:0] d_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N-2:0], v_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= d_i;
            for (int k = 1; k < N; k++) begin
                d_reg[k] <= d_reg[k-1];
            end
        end
    end

    assign v_o = v_reg[N-1];
    assign d_o = d_reg[N-1];

endmodule

[sv/pps_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// The caller guarantees num_i < den_i * 2**QW. No package dependency.
module pps_div #(
    parameter int NW = 55,
    parameter int DW = 25,
    parameter int QW = 31
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_i,
    input  logic [DW-1:0] den_i,
    output logic [QW-1:0] quo_o
);

    localparam int XW = DW + QW;

    logic [XW-1:0] rem_reg [1:QW-1];
    logic [DW-1:0] den_reg [1:QW-1];
    logic [QW-1:0] quo_reg [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [XW-1:0] rem_in;
        logic [XW-1:0] sub;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = XW'(num_i);
            assign den_in = den_i;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k];
            assign den_in = den_reg[k];
            assign quo_in = quo_reg[k];
        end

        // Stage k decides quotient bit QW-1-k.
        assign sub  = XW'(den_in) << (QW - 1 - k);
        assign take = (rem_in >= sub);

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k+1] <= {quo_in[QW-2:0], take};
            end
        end

        if (k < QW - 1) begin : g_fwd
            logic [XW-1:0] rem_next;
            assign rem_next = take ? (rem_in - sub) : rem_in;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= rem_next;
                    den_reg[k+1] <= den_in;
                end
            end
        end
    end

    assign quo_o = quo_reg[QW];

endmodule

[sv/pps_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Uses pps_pkg for the root width.
module pps_sqrt
    import pps_pkg::*;
(
    input  logic            aclk,
    input  logic            en,
    input  logic [SQ_W-1:0] rad_i,
    output logic [MAG_W-1:0] root_o
);

    localparam int RW = MAG_W;

    logic [RW:0]     rem_reg  [1:RW-1];
    logic [2*RW-1:0] rad_reg  [1:RW-1];
    logic [RW-1:0]   root_reg [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW:0]     rem_in;
        logic [2*RW-1:0] rad_in;
        logic [RW-1:0]   root_in;
        logic [RW+2:0]   rem_t;
        logic [RW+2:0]   trial;
        logic            take;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = rad_i;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k];
            assign rad_in  = rad_reg[k];
            assign root_in = root_reg[k];
        end

        // Bring down the next two radicand bits and try the bit 4r+1.
        assign rem_t = {rem_in, rad_in[2*RW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = (rem_t >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k+1] <= {root_in[RW-2:0], take};
            end
        end

        if (k < RW - 1) begin : g_fwd
            logic [RW+2:0] rem_next;
            assign rem_next = take ? (rem_t - trial) : rem_t;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= rem_next[RW:0];
                    rad_reg[k+1] <= rad_in << 2;
                end
            end
        end
    end

    assign root_o = root_reg[RW];

endmodule

[sv/particle_pair_separation_top.sv]
// Top level of the particle pair separation block.
// Uses pps_pkg, pps_delay, pps_sqrt and pps_div.

// Takes one particle pair per clock while the output is not stalled and returns
// one result per pair, in order. Most of the pipeline lies in three units that
// produce one bit per stage: the 31-stage square root of the squared distance,
// the 31-stage division that splits the overlap by inverse mass, and the
// 31-stage division of each axis correction by the distance. The pipeline
// holds as a whole while a result waits at the output and m_ready is low.
// min_separation may be rewritten only while no request is in flight.
module particle_pair_separation_top
    import pps_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [MINSEP_W-1:0]           cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_a_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_a_pos_y,
    input  logic signed [COORD_WIDTH-1:0] s_a_pos_z,
    input  logic [INVM_W-1:0]             s_a_inv_mass,
    input  logic signed [COORD_WIDTH-1:0] s_b_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_b_pos_y,
    input  logic signed [COORD_WIDTH-1:0] s_b_pos_z,
    input  logic [INVM_W-1:0]             s_b_inv_mass,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_a_new_x,
    output logic signed [COORD_WIDTH-1:0] m_a_new_y,
    output logic signed [COORD_WIDTH-1:0] m_a_new_z,
    output logic signed [COORD_WIDTH-1:0] m_b_new_x,
    output logic signed [COORD_WIDTH-1:0] m_b_new_y,
    output logic signed [COORD_WIDTH-1:0] m_b_new_z,
    output logic                          m_was_corrected
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = (CW + 1 > MAG_W + 1) ? CW + 1 : MAG_W + 1;
    localparam int EW = ((CW > MAG_W + 1) ? CW : MAG_W + 1) + 2;
    localparam int PAW = 6 * CW + 3 + 3 * MAG_W + 2 * INVM_W + WSUM_W + 1;
    localparam int PBW = 6 * CW + 3 + 3 * MAG_W + 2 * MAG_W + 1;
    localparam int PCW = 6 * CW + 3 + 1;

    logic en;
    logic [MINSEP_W-1:0] minsep_reg;

    // Stage 1: input capture.
    logic                   v1_reg;
    logic [2:0][CW-1:0]     a1_reg, b1_reg;
    logic [INVM_W-1:0]      wa1_reg, wb1_reg;

    // Stage 2: differences and magnitudes.
    logic [2:0][CW:0]       d2_full, d2_mag;
    logic [2:0][AW-1:0]     d2_ext;
    logic [2:0]             dneg2_next;
    logic [2:0][MAG_W-1:0]  ad2_next;
    logic                   far2_next;
    logic                   v2_reg, far2_reg;
    logic [2:0][CW-1:0]     a2_reg, b2_reg;
    logic [2:0]             dneg2_reg;
    logic [2:0][MAG_W-1:0]  ad2_reg;
    logic [INVM_W-1:0]      wa2_reg, wb2_reg;

    // Stage 3: squares.
    logic                   v3_reg, far3_reg;
    logic [2:0][CW-1:0]     a3_reg, b3_reg;
    logic [2:0]             dneg3_reg;
    logic [2:0][MAG_W-1:0]  ad3_reg;
    logic [INVM_W-1:0]      wa3_reg, wb3_reg;
    logic [WSUM_W-1:0]      wsum3_reg;
    logic [2:0][SQ_W-1:0]   sq3_reg;
    logic [SQ_W-1:0]        mm3_reg;

    // Stage 4: squared distance and the correction decision.
    logic [SQ_W+1:0]        s4_full;
    logic                   fix4_next;
    logic                   v4_reg, fix4_reg;
    logic [SQ_W-1:0]        s4_reg;
    logic [2:0][CW-1:0]     a4_reg, b4_reg;
    logic [2:0]             dneg4_reg;
    logic [2:0][MAG_W-1:0]  ad4_reg;
    logic [INVM_W-1:0]      wa4_reg, wb4_reg;
    logic [WSUM_W-1:0]      wsum4_reg;

    // Alongside the square root.
    logic                   va;
    logic [PAW-1:0]         pa_o;
    logic [2:0][CW-1:0]     a_a, b_a;
    logic [2:0]             dneg_a;
    logic [2:0][MAG_W-1:0]  ad_a;
    logic [INVM_W-1:0]      wa_a, wb_a;
    logic [WSUM_W-1:0]      wsum_a;
    logic                   fix_a;
    logic [MAG_W-1:0]       dist_a;

    // Stage 5 and 6: overlap and share numerators.
    logic                   v5_reg, fix5_reg;
    logic [MAG_W-1:0]       ovl5_reg, dist5_reg;
    logic [2:0][CW-1:0]     a5_reg, b5_reg;
    logic [2:0]             dneg5_reg;
    logic [2:0][MAG_W-1:0]  ad5_reg;
    logic [INVM_W-1:0]      wa5_reg, wb5_reg;
    logic [WSUM_W-1:0]      wsum5_reg;
    logic                   v6_reg, fix6_reg;
    logic [MAG_W-1:0]       ovl6_reg, dist6_reg;
    logic [2:0][CW-1:0]     a6_reg, b6_reg;
    logic [2:0]             dneg6_reg;
    logic [2:0][MAG_W-1:0]  ad6_reg;
    logic [WSUM_W-1:0]      wsum6_reg;
    logic [SHNUM_W-1:0]     pa6_reg, pb6_reg;

    // Alongside the share dividers.
    logic                   vb;
    logic [PBW-1:0]         pb_o;
    logic [2:0][CW-1:0]     a_b, b_b;
    logic [2:0]             dneg_b;
    logic [2:0][MAG_W-1:0]  ad_b;
    logic [MAG_W-1:0]       dist_b, ovl_b, sha_b, shb_b;
    logic                   fix_b;

    // Stage 7: correction numerators.
    logic                   v7_reg, fix7_reg;
    logic [MAG_W-1:0]       dist7_reg;
    logic [2:0][CW-1:0]     a7_reg, b7_reg;
    logic [2:0]             dneg7_reg;
    logic [2:0][SQ_W-1:0]   na7_reg, nb7_reg;

    // Alongside the correction dividers.
    logic                   vc;
    logic [PCW-1:0]         pc_o;
    logic [2:0][CW-1:0]     a_c, b_c;
    logic [2:0]             dneg_c;
    logic                   fix_c;
    logic [2:0][MAG_W-1:0]  corra_c, corrb_c;

    // Output stage.
    logic signed [EW-1:0]   sa8 [3];
    logic signed [EW-1:0]   sb8 [3];
    logic signed [EW-1:0]   ca8 [3];
    logic signed [EW-1:0]   cb8 [3];
    logic signed [EW-1:0]   ta8 [3];
    logic signed [EW-1:0]   tb8 [3];
    logic [2:0][CW-1:0]     ao_next, bo_next;
    logic                   mv_reg, wc_reg;
    logic [2:0][CW-1:0]     ao_reg, bo_reg;

    function automatic logic [CW-1:0] sat_c(input logic signed [EW-1:0] v);
        logic [EW-CW:0] top;
        top = v[EW-1:CW-1];
        if (top == '0 || top == '1) begin
            return v[CW-1:0];
        end
        return v[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    // The whole pipeline moves unless a result is held at the output.
    assign en      = !mv_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minsep_reg <= MINSEP_RESET;
        end else if (cfg_we) begin
            minsep_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= va;
            v6_reg <= v5_reg;
            v7_reg <= vb;
            mv_reg <= vc;
        end
    end

    always_comb begin
        far2_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d2_full[i] = {b1_reg[i][CW-1], b1_reg[i]} - {a1_reg[i][CW-1], a1_reg[i]};
            dneg2_next[i] = d2_full[i][CW];
            d2_mag[i] = dneg2_next[i] ? (~d2_full[i] + 1'b1) : d2_full[i];
            d2_ext[i] = AW'(d2_mag[i]);
            ad2_next[i] = d2_ext[i][MAG_W-1:0];
            far2_next = far2_next | (|d2_ext[i][AW-1:MAG_W]);
        end
    end

    always_comb begin
        s4_full = (SQ_W+2)'(sq3_reg[0]) + (SQ_W+2)'(sq3_reg[1]) + (SQ_W+2)'(sq3_reg[2]);
        fix4_next = (wsum3_reg != '0) && !far3_reg && (s4_full != '0)
                    && (s4_full < (SQ_W+2)'(mm3_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg    <= {s_a_pos_z, s_a_pos_y, s_a_pos_x};
            b1_reg    <= {s_b_pos_z, s_b_pos_y, s_b_pos_x};
            wa1_reg   <= s_a_inv_mass;
            wb1_reg   <= s_b_inv_mass;

            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            dneg2_reg <= dneg2_next;
            ad2_reg   <= ad2_next;
            far2_reg  <= far2_next;
            wa2_reg   <= wa1_reg;
            wb2_reg   <= wb1_reg;

            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
            dneg3_reg <= dneg2_reg;
            ad3_reg   <= ad2_reg;
            far3_reg  <= far2_reg;
            wa3_reg   <= wa2_reg;
            wb3_reg   <= wb2_reg;
            wsum3_reg <= {1'b0, wa2_reg} + {1'b0, wb2_reg};
            for (int i = 0; i < 3; i++) begin
                sq3_reg[i] <= SQ_W'(ad2_reg[i]) * SQ_W'(ad2_reg[i]);
            end
            mm3_reg   <= SQ_W'(minsep_reg) * SQ_W'(minsep_reg);

            a4_reg    <= a3_reg;
            b4_reg    <= b3_reg;
            dneg4_reg <= dneg3_reg;
            ad4_reg   <= ad3_reg;
            wa4_reg   <= wa3_reg;
            wb4_reg   <= wb3_reg;
            wsum4_reg <= wsum3_reg;
            s4_reg    <= s4_full[SQ_W-1:0];
            fix4_reg  <= fix4_next;
        end
    end

    pps_delay #(.W(PAW), .N(MAG_W)) u_dly_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .v_i     (v4_reg),
        .d_i     ({a4_reg, b4_reg, dneg4_reg, ad4_reg, wa4_reg, wb4_reg, wsum4_reg,
                   fix4_reg}),
        .v_o     (va),
        .d_o     (pa_o)
    );

    assign {a_a, b_a, dneg_a, ad_a, wa_a, wb_a, wsum_a, fix_a} = pa_o;

    pps_sqrt u_sqrt (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (s4_reg),
        .root_o (dist_a)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            a5_reg    <= a_a;
            b5_reg    <= b_a;
            dneg5_reg <= dneg_a;
            ad5_reg   <= ad_a;
            wa5_reg   <= wa_a;
            wb5_reg   <= wb_a;
            wsum5_reg <= wsum_a;
            fix5_reg  <= fix_a;
            dist5_reg <= dist_a;
            ovl5_reg  <= minsep_reg - dist_a;

            a6_reg    <= a5_reg;
            b6_reg    <= b5_reg;
            dneg6_reg <= dneg5_reg;
            ad6_reg   <= ad5_reg;
            wsum6_reg <= wsum5_reg;
            fix6_reg  <= fix5_reg;
            dist6_reg <= dist5_reg;
            ovl6_reg  <= ovl5_reg;
            pa6_reg   <= SHNUM_W'(ovl5_reg) * SHNUM_W'(wa5_reg);
            pb6_reg   <= SHNUM_W'(ovl5_reg) * SHNUM_W'(wb5_reg);
        end
    end

    pps_delay #(.W(PBW), .N(MAG_W)) u_dly_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .v_i     (v6_reg),
        .d_i     ({a6_reg, b6_reg, dneg6_reg, ad6_reg, dist6_reg, ovl6_reg, fix6_reg}),
        .v_o     (vb),
        .d_o     (pb_o)
    );

    assign {a_b, b_b, dneg_b, ad_b, dist_b, ovl_b, fix_b} = pb_o;

    pps_div #(.NW(SHNUM_W), .DW(WSUM_W), .QW(MAG_W)) u_div_sha (
        .aclk  (aclk),
        .en    (en),
        .num_i (pa6_reg),
        .den_i (wsum6_reg),
        .quo_o (sha_b)
    );

    pps_div #(.NW(SHNUM_W), .DW(WSUM_W), .QW(MAG_W)) u_div_shb (
        .aclk  (aclk),
        .en    (en),
        .num_i (pb6_reg),
        .den_i (wsum6_reg),
        .quo_o (shb_b)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            a7_reg    <= a_b;
            b7_reg    <= b_b;
            dneg7_reg <= dneg_b;
            fix7_reg  <= fix_b;
            dist7_reg <= dist_b;
            for (int i = 0; i < 3; i++) begin
                na7_reg[i] <= SQ_W'(ad_b[i]) * SQ_W'(sha_b);
                nb7_reg[i] <= SQ_W'(ad_b[i]) * SQ_W'(shb_b);
            end
        end
    end

    pps_delay #(.W(PCW), .N(MAG_W)) u_dly_c (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .v_i     (v7_reg),
        .d_i     ({a7_reg, b7_reg, dneg7_reg, fix7_reg}),
        .v_o     (vc),
        .d_o     (pc_o)
    );

    assign {a_c, b_c, dneg_c, fix_c} = pc_o;

    // Each axis correction is |d| * share / dist; |d| never exceeds dist.
    for (genvar i = 0; i < 3; i++) begin : g_axis
        pps_div #(.NW(SQ_W), .DW(MAG_W), .QW(MAG_W)) u_div_ca (
            .aclk  (aclk),
            .en    (en),
            .num_i (na7_reg[i]),
            .den_i (dist7_reg),
            .quo_o (corra_c[i])
        );

        pps_div #(.NW(SQ_W), .DW(MAG_W), .QW(MAG_W)) u_div_cb (
            .aclk  (aclk),
            .en    (en),
            .num_i (nb7_reg[i]),
            .den_i (dist7_reg),
            .quo_o (corrb_c[i])
        );
    end

    // Particle a moves against d and particle b along it.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sa8[i] = EW'($signed(a_c[i]));
            sb8[i] = EW'($signed(b_c[i]));
            ca8[i] = $signed(EW'(corra_c[i]));
            cb8[i] = $signed(EW'(corrb_c[i]));
            ta8[i] = dneg_c[i] ? (sa8[i] + ca8[i]) : (sa8[i] - ca8[i]);
            tb8[i] = dneg_c[i] ? (sb8[i] - cb8[i]) : (sb8[i] + cb8[i]);
            ao_next[i] = fix_c ? sat_c(ta8[i]) : a_c[i];
            bo_next[i] = fix_c ? sat_c(tb8[i]) : b_c[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ao_reg <= ao_next;
            bo_reg <= bo_next;
            wc_reg <= fix_c;
        end
    end

    assign m_valid         = mv_reg;
    assign m_a_new_x       = ao_reg[0];
    assign m_a_new_y       = ao_reg[1];
    assign m_a_new_z       = ao_reg[2];
    assign m_b_new_x       = bo_reg[0];
    assign m_b_new_y       = bo_reg[1];
    assign m_b_new_z       = bo_reg[2];
    assign m_was_corrected = wc_reg;

`ifndef SYNTH
    // A corrected pair always has a nonzero distance below the minimum.
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        va && fix_a |-> (dist_a != '0) && (dist_a < minsep_reg))
        else $error("square root out of range for a corrected pair");

    // The two rounded-down shares never add up to more than the overlap.
    a_share_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        vb && fix_b |-> ({1'b0, sha_b} + {1'b0, shb_b}) <= {1'b0, ovl_b})
        else $error("overlap shares exceed the overlap");
`endif

endmodule
